[rtl/permutation_threshold_tracker_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the permutation threshold tracker
// Concurrent checks clocked by i_clk and disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef PERMUTATION_THRESHOLD_TRACKER_ASSERT_SVH
`define PERMUTATION_THRESHOLD_TRACKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PTT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ptt_pkg.sv]
// ---------------------------------------------------------------------------
// ptt_pkg
// Widths, codes, reset values and shared types of the threshold tracker.
// ---------------------------------------------------------------------------
package ptt_pkg;

    localparam int ACT_W      = 3;
    localparam int IDX_W      = 11;
    localparam int PV_W       = 32;
    localparam int CNT_O_W    = 11;
    localparam int REG_W      = 11;
    localparam int KK_W       = 7;
    localparam int HC_W       = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int OP_W       = 5;

    localparam logic [PV_W-1:0] PV_ONE = '1;

    // Actions of an input word.
    localparam logic [ACT_W-1:0] ACT_LOAD    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PERM    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_TOPK    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SETTLE  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RESTART = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_K_KEEP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FP_LIMIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_THR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_MS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF      = 3'd4;

    // Configuration reset values.
    localparam logic [KK_W-1:0]    RST_K_KEEP   = 7'd1;
    localparam logic [REG_W-1:0]   RST_FP_LIMIT = 11'd51;
    localparam logic [PV_W-1:0]    RST_INIT_THR = 32'd214748365;
    localparam logic [REG_W-1:0]   RST_INIT_MS  = 11'd0;
    localparam logic [HC_W-1:0]    RST_HALF     = 10'd512;

    // Datapath operations issued by the controller.
    localparam logic [OP_W-1:0] OP_NONE     = 5'd0;
    localparam logic [OP_W-1:0] OP_ACCEPT   = 5'd1;
    localparam logic [OP_W-1:0] OP_CLEAR    = 5'd2;
    localparam logic [OP_W-1:0] OP_P1       = 5'd3;
    localparam logic [OP_W-1:0] OP_PUSH     = 5'd4;
    localparam logic [OP_W-1:0] OP_SCAN_MAX = 5'd5;
    localparam logic [OP_W-1:0] OP_EVICT_RD = 5'd6;
    localparam logic [OP_W-1:0] OP_EVICT_WR = 5'd7;
    localparam logic [OP_W-1:0] OP_SCAN_KTH = 5'd8;
    localparam logic [OP_W-1:0] OP_ADV_RD   = 5'd9;
    localparam logic [OP_W-1:0] OP_ADV_CHK  = 5'd10;
    localparam logic [OP_W-1:0] OP_TMIN     = 5'd11;
    localparam logic [OP_W-1:0] OP_RECNT    = 5'd12;
    localparam logic [OP_W-1:0] OP_SET_TEST = 5'd13;
    localparam logic [OP_W-1:0] OP_SH_RA    = 5'd14;
    localparam logic [OP_W-1:0] OP_SH_RB    = 5'd15;
    localparam logic [OP_W-1:0] OP_SH_CMP   = 5'd16;
    localparam logic [OP_W-1:0] OP_SH_RC    = 5'd17;
    localparam logic [OP_W-1:0] OP_SH_MIN   = 5'd18;
    localparam logic [OP_W-1:0] OP_DONE     = 5'd19;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } t_cmd;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic             perm_ok;
        logic             clr_last;
        logic             overflow;
        logic             scan_done;
        logic             adv_go;
        logic             adv_more;
        logic             rc_done;
        logic             shrink_go;
        logic             side;
        logic             out_free;
    } t_stat;

    function automatic logic [PV_W-1:0] pv_min(input logic [PV_W-1:0] a,
                                               input logic [PV_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

endpackage

[rtl/ptt_in_if.sv]
// ---------------------------------------------------------------------------
// ptt_in_if
// Input word channel: valid, ready and the action payload.
// ---------------------------------------------------------------------------
interface ptt_in_if import ptt_pkg::*;;
    logic             valid;
    logic             ready;
    logic [ACT_W-1:0] action;
    logic [IDX_W-1:0] index;
    logic [PV_W-1:0]  pvalue;

    modport source (output valid, output action, output index, output pvalue, input ready);
    modport sink   (input valid, input action, input index, input pvalue, output ready);
endinterface

[rtl/ptt_out_if.sv]
// ---------------------------------------------------------------------------
// ptt_out_if
// Result word channel: valid, ready and the tracker status payload.
// ---------------------------------------------------------------------------
interface ptt_out_if import ptt_pkg::*;;
    logic               valid;
    logic               ready;
    logic [PV_W-1:0]    threshold;
    logic [CNT_O_W-1:0] min_support;
    logic [CNT_O_W-1:0] fp_total;
    logic [PV_W-1:0]    kth_pvalue;
    logic               threshold_lowered;

    modport source (output valid, output threshold, output min_support,
                    output fp_total, output kth_pvalue,
                    output threshold_lowered, input ready);
    modport sink   (input valid, input threshold, input min_support,
                    input fp_total, input kth_pvalue,
                    input threshold_lowered, output ready);
endinterface

[rtl/permutation_threshold_tracker.sv]
// ---------------------------------------------------------------------------
// permutation_threshold_tracker
// Permutation-test significance threshold tracker with top-k store.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Handshake       Contents
//   i_item    in         valid / ready   action, index, pvalue
//   o_result  out        valid / ready   threshold, min_support,
//                                        fp_total, kth_pvalue,
//                                        threshold_lowered
//   i_cfg_*   in         write enable    register index, write data
//
// A table load or an unused action runs only the accept and done steps, a
// permutation offer adds the P1 step and a push that does not overflow the
// push step; these follow the controller's one-state-per-step sequence and
// the registered RAM reads. A push that overflows adds two scans of the top-k
// store, the support steps and a recount over all permutation minima.
// Each settle shrink step ends in a recount, the recount dominating.
// Restart and reset both run a clearing pass over every entry of the
// permutation minimum RAM; no word is accepted while it runs.
// A word is taken while the previous result still waits in the output
// register; the result stalls only the final step of the next word.
//
module permutation_threshold_tracker import ptt_pkg::*; #(
    parameter int PERMS    = 1024,
    parameter int MAX_OBS  = 1024,
    parameter int TOPK_MAX = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ptt_in_if.sink                i_item,
    ptt_out_if.source             o_result
);

`include "permutation_threshold_tracker_assert.svh"

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_ready;

    // The controller sequences each action; the datapath holds the tracker state.
    ptt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_item.valid),
        .o_ready (w_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    ptt_dp #(
        .PERMS    (PERMS),
        .MAX_OBS  (MAX_OBS),
        .TOPK_MAX (TOPK_MAX)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_cmd               (w_cmd),
        .o_stat              (w_stat),
        .i_action            (i_item.action),
        .i_index             (i_item.index),
        .i_pvalue            (i_item.pvalue),
        .i_out_ready         (o_result.ready),
        .o_out_valid         (o_result.valid),
        .o_threshold         (o_result.threshold),
        .o_min_support       (o_result.min_support),
        .o_fp_total          (o_result.fp_total),
        .o_kth_pvalue        (o_result.kth_pvalue),
        .o_threshold_lowered (o_result.threshold_lowered)
    );

    assign i_item.ready = w_ready;

    // Every accepted word starts the datapath in the same cycle.
    `PTT_ASSERT_IMP(a_accept_op, (i_item.valid && i_item.ready), (w_cmd.op == OP_ACCEPT), "accept without datapath start")
    // Only one word is in work at a time.
    `PTT_ASSERT_NXT(a_one_word, (i_item.valid && i_item.ready), (!i_item.ready), "second word taken while busy")
    // A result is loaded only into a free output register.
    `PTT_ASSERT_IMP(a_done_free, (w_cmd.op == OP_DONE), (!o_result.valid || o_result.ready), "result overwrites pending word")
    // A finished word shows up as a valid result.
    `PTT_ASSERT_NXT(a_done_valid, (w_cmd.op == OP_DONE), (o_result.valid), "finished word not presented")

endmodule

[rtl/ptt_ram.sv]
// ---------------------------------------------------------------------------
// ptt_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module ptt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/ptt_ctrl.sv]
// ---------------------------------------------------------------------------
// ptt_ctrl
// Sequencer that steps the datapath through each action of a word.
// ---------------------------------------------------------------------------
module ptt_ctrl import ptt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_CLEAR    = 5'd1;
    localparam logic [4:0] S_P1       = 5'd2;
    localparam logic [4:0] S_PUSH     = 5'd3;
    localparam logic [4:0] S_SCAN_MAX = 5'd4;
    localparam logic [4:0] S_EVICT_RD = 5'd5;
    localparam logic [4:0] S_EVICT_WR = 5'd6;
    localparam logic [4:0] S_SCAN_KTH = 5'd7;
    localparam logic [4:0] S_ADV_RD   = 5'd8;
    localparam logic [4:0] S_ADV_CHK  = 5'd9;
    localparam logic [4:0] S_TMIN     = 5'd10;
    localparam logic [4:0] S_RECNT    = 5'd11;
    localparam logic [4:0] S_SET_TEST = 5'd12;
    localparam logic [4:0] S_SH_RA    = 5'd13;
    localparam logic [4:0] S_SH_RB    = 5'd14;
    localparam logic [4:0] S_SH_CMP   = 5'd15;
    localparam logic [4:0] S_SH_RC    = 5'd16;
    localparam logic [4:0] S_SH_MIN   = 5'd17;
    localparam logic [4:0] S_DONE     = 5'd18;

    logic [4:0]       r_state, n_state;
    logic [ACT_W-1:0] r_act, n_act;
    logic             w_accept;
    logic [4:0]       w_after_adv;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = o_ready && i_valid;

    // Restart ends after the support advance; a push goes on to the threshold.
    assign w_after_adv = (r_act == ACT_RESTART) ? S_DONE : S_TMIN;

    always_comb begin
        n_state   = r_state;
        n_act     = r_act;
        o_cmd.op  = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.op = OP_ACCEPT;
                    n_act    = i_stat.act;
                    case (i_stat.act)
                        ACT_LOAD:    n_state = S_DONE;
                        ACT_PERM:    n_state = i_stat.perm_ok ? S_P1 : S_DONE;
                        ACT_TOPK:    n_state = S_PUSH;
                        ACT_SETTLE:  n_state = S_SET_TEST;
                        ACT_RESTART: n_state = S_CLEAR;
                        default:     n_state = S_DONE;
                    endcase
                end
            end
            S_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                if (i_stat.clr_last) begin
                    n_state = (r_act == ACT_RESTART) ? S_ADV_RD : S_IDLE;
                end
            end
            S_P1: begin
                o_cmd.op = OP_P1;
                n_state  = S_DONE;
            end
            S_PUSH: begin
                o_cmd.op = OP_PUSH;
                n_state  = i_stat.overflow ? S_SCAN_MAX : S_DONE;
            end
            S_SCAN_MAX: begin
                o_cmd.op = OP_SCAN_MAX;
                if (i_stat.scan_done) begin
                    n_state = S_EVICT_RD;
                end
            end
            S_EVICT_RD: begin
                o_cmd.op = OP_EVICT_RD;
                n_state  = S_EVICT_WR;
            end
            S_EVICT_WR: begin
                o_cmd.op = OP_EVICT_WR;
                n_state  = S_SCAN_KTH;
            end
            S_SCAN_KTH: begin
                o_cmd.op = OP_SCAN_KTH;
                if (i_stat.scan_done) begin
                    n_state = S_ADV_RD;
                end
            end
            S_ADV_RD: begin
                o_cmd.op = OP_ADV_RD;
                n_state  = i_stat.adv_go ? S_ADV_CHK : w_after_adv;
            end
            S_ADV_CHK: begin
                o_cmd.op = OP_ADV_CHK;
                n_state  = i_stat.adv_more ? S_ADV_RD : w_after_adv;
            end
            S_TMIN: begin
                o_cmd.op = OP_TMIN;
                n_state  = S_RECNT;
            end
            S_RECNT: begin
                o_cmd.op = OP_RECNT;
                if (i_stat.rc_done) begin
                    n_state = (r_act == ACT_SETTLE) ? S_SET_TEST : S_DONE;
                end
            end
            S_SET_TEST: begin
                o_cmd.op = OP_SET_TEST;
                n_state  = i_stat.shrink_go ? S_SH_RA : S_DONE;
            end
            S_SH_RA: begin
                o_cmd.op = OP_SH_RA;
                n_state  = S_SH_RB;
            end
            S_SH_RB: begin
                o_cmd.op = OP_SH_RB;
                n_state  = S_SH_CMP;
            end
            S_SH_CMP: begin
                o_cmd.op = OP_SH_CMP;
                n_state  = i_stat.side ? S_SH_RC : S_RECNT;
            end
            S_SH_RC: begin
                o_cmd.op = OP_SH_RC;
                n_state  = S_SH_MIN;
            end
            S_SH_MIN: begin
                o_cmd.op = OP_SH_MIN;
                n_state  = S_RECNT;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_DONE;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_act   <= ACT_LOAD;
        end else begin
            r_state <= n_state;
            r_act   <= n_act;
        end
    end

endmodule

[rtl/ptt_dp.sv]
// ---------------------------------------------------------------------------
// ptt_dp
// Datapath: configuration, tracker registers, the three RAMs and the scans.
// ---------------------------------------------------------------------------
module ptt_dp import ptt_pkg::*; #(
    parameter int PERMS    = 1024,
    parameter int MAX_OBS  = 1024,
    parameter int TOPK_MAX = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic [ACT_W-1:0]      i_action,
    input  logic [IDX_W-1:0]      i_index,
    input  logic [PV_W-1:0]       i_pvalue,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [PV_W-1:0]       o_threshold,
    output logic [CNT_O_W-1:0]    o_min_support,
    output logic [CNT_O_W-1:0]    o_fp_total,
    output logic [PV_W-1:0]       o_kth_pvalue,
    output logic                  o_threshold_lowered
);

    localparam int PW   = $clog2(PERMS);
    localparam int PCW  = $clog2(PERMS + 1);
    localparam int AW   = $clog2(MAX_OBS + 1);
    localparam int MSW  = (AW > REG_W) ? AW : REG_W;
    localparam int TAW  = $clog2(TOPK_MAX + 1);
    localparam int CW   = $clog2(TOPK_MAX + 2);

    // Configuration.
    logic [KK_W-1:0]  r_k_keep;
    logic [REG_W-1:0] r_fp_limit;
    logic [PV_W-1:0]  r_init_thr;
    logic [REG_W-1:0] r_init_ms;
    logic [HC_W-1:0]  r_half;

    // Tracker state.
    logic [PV_W-1:0]  r_thr;
    logic [PV_W-1:0]  r_kth;
    logic [MSW-1:0]   r_ms;
    logic [REG_W-1:0] r_low;
    logic [REG_W-1:0] r_high;
    logic             r_side;
    logic [PCW-1:0]   r_fp;
    logic [CW-1:0]    r_cnt;
    logic [ACT_W-1:0] r_act;

    // Sweep and scan control.
    logic [PCW-1:0]   r_pidx;
    logic             r_prv;
    logic [PCW-1:0]   r_acc;
    logic [CW-1:0]    r_tidx;
    logic             r_tv;

    // Payload.
    logic [IDX_W-1:0] r_idx;
    logic [PV_W-1:0]  r_pv;
    logic [PV_W-1:0]  r_before;
    logic [PV_W-1:0]  r_pa;
    logic [PV_W-1:0]  r_max;
    logic [TAW-1:0]   r_big;
    logic [TAW-1:0]   r_ridx;

    logic               r_o_valid;
    logic [PV_W-1:0]    r_o_thr;
    logic [CNT_O_W-1:0] r_o_ms;
    logic [CNT_O_W-1:0] r_o_fp;
    logic [PV_W-1:0]    r_o_kth;
    logic               r_o_low;

    // RAM ports.
    logic            w_psi_we;
    logic [AW-1:0]   w_psi_raddr;
    logic [PV_W-1:0] w_psi_rdata;
    logic            w_perm_we;
    logic [PW-1:0]   w_perm_waddr;
    logic [PV_W-1:0] w_perm_wdata;
    logic [PW-1:0]   w_perm_raddr;
    logic [PV_W-1:0] w_perm_rdata;
    logic            w_st_we;
    logic [TAW-1:0]  w_st_waddr;
    logic [PV_W-1:0] w_st_wdata;
    logic [TAW-1:0]  w_st_raddr;
    logic [PV_W-1:0] w_st_rdata;

    logic [CW-1:0]   w_k_eff;
    logic            w_cnt_room;
    logic [CW-1:0]   w_cnt_new;
    logic [CW-1:0]   w_cnt_m1;
    logic [AW-1:0]   w_low_a;
    logic [AW-1:0]   w_high_a;
    logic [AW-1:0]   w_ms_a;
    logic [MSW-1:0]  w_init_ms;
    logic            w_tissue;
    logic            w_scan_take;
    logic [PV_W-1:0] w_scan_max;
    logic            w_scan_done;
    logic            w_pissue;
    logic            w_hit;
    logic [PCW-1:0]  w_acc_next;
    logic            w_rc_done;
    logic [PV_W-1:0] w_bound;
    logic            w_p1_lower;
    logic            w_p1_cross;
    logic            w_shrink_go;
    logic            w_pa_ge;

    // The kept count is clamped to 1..TOPK_MAX.
    always_comb begin
        if (r_k_keep == '0) begin
            w_k_eff = CW'(1);
        end else if (32'(r_k_keep) > 32'(TOPK_MAX)) begin
            w_k_eff = CW'(TOPK_MAX);
        end else begin
            w_k_eff = CW'(r_k_keep);
        end
    end

    assign w_cnt_room = 32'(r_cnt) <= 32'(TOPK_MAX);
    assign w_cnt_new  = w_cnt_room ? r_cnt + CW'(1) : r_cnt;
    assign w_cnt_m1   = r_cnt - CW'(1);

    // Table reads beyond the last entry use the last entry.
    assign w_low_a  = (32'(r_low) > 32'(MAX_OBS)) ? AW'(MAX_OBS) : AW'(r_low);
    assign w_high_a = (32'(r_high) > 32'(MAX_OBS)) ? AW'(MAX_OBS) : AW'(r_high);
    assign w_ms_a   = (32'(r_ms) > 32'(MAX_OBS)) ? AW'(MAX_OBS) : AW'(r_ms);
    assign w_init_ms = (32'(r_init_ms) > 32'(MAX_OBS)) ? MSW'(MAX_OBS) : MSW'(r_init_ms);

    // Top-k scan: one address issued per cycle, data compared in the cycle after.
    assign w_tissue    = r_tidx < r_cnt;
    assign w_scan_take = (r_ridx == '0) || (w_st_rdata > r_max);
    assign w_scan_max  = w_scan_take ? w_st_rdata : r_max;
    assign w_scan_done = r_tv && (CW'(r_ridx) == w_cnt_m1);

    // Recount sweep over all permutation minima.
    assign w_pissue   = 32'(r_pidx) < 32'(PERMS);
    assign w_hit      = r_prv && (w_perm_rdata <= r_thr);
    assign w_acc_next = r_acc + PCW'(w_hit);
    assign w_rc_done  = r_prv && !w_pissue;

    assign w_bound     = (r_act == ACT_RESTART) ? r_thr : r_kth;
    assign w_p1_lower  = r_pv < w_perm_rdata;
    assign w_p1_cross  = (r_pv <= r_thr) && (w_perm_rdata > r_thr);
    assign w_shrink_go = (32'(r_fp) > 32'(r_fp_limit)) && (r_low < r_high);
    assign w_pa_ge     = r_pa >= w_psi_rdata;

    // RAM address and write selection.
    assign w_psi_we = (i_cmd.op == OP_ACCEPT) && (i_action == ACT_LOAD)
                      && (32'(i_index) <= 32'(MAX_OBS));

    always_comb begin
        case (i_cmd.op)
            OP_SH_RA: w_psi_raddr = w_low_a;
            OP_SH_RB: w_psi_raddr = w_high_a;
            default:  w_psi_raddr = w_ms_a;
        endcase
    end

    assign w_perm_we    = (i_cmd.op == OP_CLEAR) || ((i_cmd.op == OP_P1) && w_p1_lower);
    assign w_perm_waddr = (i_cmd.op == OP_CLEAR) ? r_pidx[PW-1:0] : PW'(r_idx);
    assign w_perm_wdata = (i_cmd.op == OP_CLEAR) ? PV_ONE : r_pv;
    assign w_perm_raddr = (i_cmd.op == OP_ACCEPT) ? PW'(i_index) : r_pidx[PW-1:0];

    assign w_st_we    = ((i_cmd.op == OP_PUSH) && w_cnt_room) || (i_cmd.op == OP_EVICT_WR);
    assign w_st_waddr = (i_cmd.op == OP_PUSH) ? r_cnt[TAW-1:0] : r_big;
    assign w_st_wdata = (i_cmd.op == OP_PUSH) ? r_pv : w_st_rdata;
    assign w_st_raddr = (i_cmd.op == OP_EVICT_RD) ? w_cnt_m1[TAW-1:0] : r_tidx[TAW-1:0];

    ptt_ram #(.WIDTH(PV_W), .DEPTH(MAX_OBS + 1)) u_psi_ram (
        .i_clk   (i_clk),
        .i_we    (w_psi_we),
        .i_waddr (AW'(i_index)),
        .i_wdata (i_pvalue),
        .i_raddr (w_psi_raddr),
        .o_rdata (w_psi_rdata)
    );

    ptt_ram #(.WIDTH(PV_W), .DEPTH(PERMS)) u_perm_ram (
        .i_clk   (i_clk),
        .i_we    (w_perm_we),
        .i_waddr (w_perm_waddr),
        .i_wdata (w_perm_wdata),
        .i_raddr (w_perm_raddr),
        .o_rdata (w_perm_rdata)
    );

    ptt_ram #(.WIDTH(PV_W), .DEPTH(TOPK_MAX + 1)) u_topk_ram (
        .i_clk   (i_clk),
        .i_we    (w_st_we),
        .i_waddr (w_st_waddr),
        .i_wdata (w_st_wdata),
        .i_raddr (w_st_raddr),
        .o_rdata (w_st_rdata)
    );

    // Control and tracker state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_keep   <= RST_K_KEEP;
            r_fp_limit <= RST_FP_LIMIT;
            r_init_thr <= RST_INIT_THR;
            r_init_ms  <= RST_INIT_MS;
            r_half     <= RST_HALF;
            r_thr      <= RST_INIT_THR;
            r_kth      <= PV_ONE;
            r_ms       <= MSW'(RST_INIT_MS);
            r_low      <= REG_W'(1);
            r_high     <= REG_W'(RST_HALF);
            r_side     <= 1'b1;
            r_fp       <= '0;
            r_cnt      <= '0;
            r_act      <= ACT_LOAD;
            r_pidx     <= '0;
            r_prv      <= 1'b0;
            r_acc      <= '0;
            r_tidx     <= '0;
            r_tv       <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_K_KEEP:   r_k_keep   <= i_cfg_data[KK_W-1:0];
                    CFG_FP_LIMIT: r_fp_limit <= i_cfg_data[REG_W-1:0];
                    CFG_INIT_THR: r_init_thr <= i_cfg_data[PV_W-1:0];
                    CFG_INIT_MS:  r_init_ms  <= i_cfg_data[REG_W-1:0];
                    CFG_HALF:     r_half     <= i_cfg_data[HC_W-1:0];
                    default: ;
                endcase
            end
            // A new result fills the output register; otherwise it empties
            // once the receiver takes the word.
            if (i_cmd.op == OP_DONE) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
            case (i_cmd.op)
                OP_ACCEPT: begin
                    r_act <= i_action;
                    if (i_action == ACT_RESTART) begin
                        r_thr  <= r_init_thr;
                        r_kth  <= PV_ONE;
                        r_cnt  <= '0;
                        r_low  <= REG_W'(1);
                        r_high <= REG_W'(r_half);
                        r_side <= 1'b1;
                        r_ms   <= w_init_ms;
                        r_fp   <= '0;
                        r_pidx <= '0;
                    end
                end
                OP_CLEAR: begin
                    r_pidx <= r_pidx + PCW'(1);
                end
                OP_P1: begin
                    if (w_p1_lower && w_p1_cross) begin
                        r_fp <= r_fp + PCW'(1);
                    end
                end
                OP_PUSH: begin
                    r_cnt  <= w_cnt_new;
                    r_tidx <= '0;
                    r_tv   <= 1'b0;
                end
                OP_SCAN_MAX: begin
                    if (w_tissue) begin
                        r_tidx <= r_tidx + CW'(1);
                    end
                    r_tv <= w_tissue;
                end
                OP_EVICT_WR: begin
                    r_cnt  <= w_cnt_m1;
                    r_tidx <= '0;
                    r_tv   <= 1'b0;
                end
                OP_SCAN_KTH: begin
                    if (w_tissue) begin
                        r_tidx <= r_tidx + CW'(1);
                    end
                    r_tv <= w_tissue;
                    if (w_scan_done) begin
                        r_kth <= w_scan_max;
                    end
                end
                OP_ADV_CHK: begin
                    if (w_psi_rdata > w_bound) begin
                        r_ms <= r_ms + MSW'(1);
                    end
                end
                OP_TMIN: begin
                    r_thr  <= pv_min(r_thr, r_kth);
                    r_pidx <= '0;
                    r_prv  <= 1'b0;
                    r_acc  <= '0;
                end
                OP_RECNT: begin
                    if (w_pissue) begin
                        r_pidx <= r_pidx + PCW'(1);
                    end
                    r_prv <= w_pissue;
                    r_acc <= w_acc_next;
                    if (w_rc_done) begin
                        r_fp <= w_acc_next;
                    end
                end
                OP_SET_TEST: begin
                    if (w_shrink_go) begin
                        if (r_side) begin
                            r_low <= r_low + REG_W'(1);
                        end else begin
                            r_high <= r_high - REG_W'(1);
                        end
                    end
                end
                OP_SH_CMP: begin
                    // The larger of the two bounds' table values caps the threshold.
                    if (w_pa_ge) begin
                        r_thr <= pv_min(r_pa, r_thr);
                        if (!r_side) begin
                            r_side <= 1'b1;
                        end
                    end else begin
                        r_thr <= pv_min(w_psi_rdata, r_thr);
                        if (r_side) begin
                            r_side <= 1'b0;
                        end
                    end
                    if (r_side && (MSW'(r_low) > r_ms)) begin
                        r_ms <= MSW'(r_low);
                    end
                    if (!r_side) begin
                        r_pidx <= '0;
                        r_prv  <= 1'b0;
                        r_acc  <= '0;
                    end
                end
                OP_SH_MIN: begin
                    r_thr  <= pv_min(w_psi_rdata, r_thr);
                    r_pidx <= '0;
                    r_prv  <= 1'b0;
                    r_acc  <= '0;
                end
                default: ;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_ACCEPT: begin
                r_idx    <= i_index;
                r_pv     <= i_pvalue;
                r_before <= r_thr;
            end
            OP_SCAN_MAX, OP_SCAN_KTH: begin
                if (w_tissue) begin
                    r_ridx <= r_tidx[TAW-1:0];
                end
                if (r_tv) begin
                    r_max <= w_scan_max;
                    if (w_scan_take) begin
                        r_big <= r_ridx;
                    end
                end
            end
            OP_SH_RB: begin
                r_pa <= w_psi_rdata;
            end
            OP_DONE: begin
                r_o_thr <= r_thr;
                r_o_ms  <= CNT_O_W'(r_ms);
                r_o_fp  <= (32'(r_fp) > 32'(11'h7FF)) ? 11'h7FF : CNT_O_W'(r_fp);
                r_o_kth <= r_kth;
                r_o_low <= (r_act != ACT_RESTART) && (r_thr < r_before);
            end
            default: ;
        endcase
    end

    assign o_out_valid         = r_o_valid;
    assign o_threshold         = r_o_thr;
    assign o_min_support       = r_o_ms;
    assign o_fp_total          = r_o_fp;
    assign o_kth_pvalue        = r_o_kth;
    assign o_threshold_lowered = r_o_low;

    assign o_stat.act       = i_action;
    assign o_stat.perm_ok   = 32'(i_index) < 32'(PERMS);
    assign o_stat.clr_last  = 32'(r_pidx) == 32'(PERMS - 1);
    assign o_stat.overflow  = w_cnt_new > w_k_eff;
    assign o_stat.scan_done = w_scan_done;
    assign o_stat.adv_go    = 32'(r_ms) < 32'(MAX_OBS);
    assign o_stat.adv_more  = w_psi_rdata > w_bound;
    assign o_stat.rc_done   = w_rc_done;
    assign o_stat.shrink_go = w_shrink_go;
    assign o_stat.side      = r_side;
    assign o_stat.out_free  = !r_o_valid || i_out_ready;

endmodule
